// ===== rtl/encoder_accel_target_setpoint_top_assert.svh =====
// Assertion macros for the encoder target setpoint block.
// Used by encoder_accel_target_setpoint_top; expects clk and arst_n in scope.
`ifndef ENCODER_ACCEL_TARGET_SETPOINT_TOP_ASSERT_SVH
`define ENCODER_ACCEL_TARGET_SETPOINT_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define EATS_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("assertion failed");
`define EATS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define EATS_ASSERT(lbl, prop)
`define EATS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/eats_pkg.sv =====
// Package for the encoder target setpoint block: payload types and constants.
// No dependencies.
`timescale 1ns / 1ps

package eats_pkg;

	typedef struct packed {
		logic        direction_up;
		logic [31:0] tick_ms;
	} det_t;

	typedef struct packed {
		logic [9:0] target_value;
		logic [4:0] step_applied;
	} tgt_t;

	localparam logic [1:0] CFG_PRESET_MODE = 2'd0;
	localparam logic [1:0] CFG_TARGET_MAX  = 2'd1;
	localparam logic [1:0] CFG_TARGET_MIN  = 2'd2;
	localparam logic [1:0] CFG_WINDOW_MS   = 2'd3;

	localparam logic [9:0]  RST_TARGET_MAX = 10'd450;
	localparam logic [9:0]  RST_TARGET_MIN = 10'd200;
	localparam logic [15:0] RST_WINDOW_MS  = 16'd500;
	localparam logic [9:0]  RST_TARGET     = 10'd300;
	localparam logic [1:0]  RST_PRESET_IDX = 2'd1;

	localparam logic [4:0] STEP_UNIT      = 5'd5;
	localparam logic [3:0] COUNT_MAX      = 4'd15;
	localparam logic [1:0] PRESET_IDX_MAX = 2'd3;
	localparam logic [9:0] PRESET_BASE    = 10'd300;
	localparam logic [9:0] PRESET_SPACING = 10'd50;

endpackage

// ===== rtl/encoder_accel_target_setpoint_top.sv =====
// Encoder detent to target setpoint with rotation acceleration.
// Depends on eats_pkg and encoder_accel_target_setpoint_top_assert.svh.
`timescale 1ns / 1ps
`include "encoder_accel_target_setpoint_top_assert.svh"

// One detent request is taken every clock cycle while the result is not stalled; it
// passes one input register and one result register in turn, and the setpoint
// state is read and updated in the single stage between them, so back-to-back
// detents see each other's updates. A stalled result holds the pipe; the input
// register still takes one request while the result waits. Configuration
// writes are always ready and must only be issued while the block is idle.
module encoder_accel_target_setpoint_top
	import eats_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       det_valid,
	output logic       det_ready,
	input  det_t       det,
	output logic       tgt_valid,
	input  logic       tgt_ready,
	output tgt_t       tgt,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [15:0] cfg_data
);

	logic        preset_mode_q;
	logic [9:0]  target_max_q;
	logic [9:0]  target_min_q;
	logic [15:0] window_q;

	logic [31:0] last_time_q;
	logic [3:0]  count_q;
	logic [9:0]  target_q;
	logic [1:0]  preset_idx_q;

	logic        valid_s1;
	det_t        det_s1;
	logic        tgt_valid_q;
	tgt_t        tgt_q;
	logic        adv;

	logic [31:0]        gap;
	logic               restart;
	logic [3:0]         count_n;
	logic [4:0]         step;
	logic               take_step;
	logic [10:0]        up_sum;
	logic signed [10:0] dn_diff;
	logic [9:0]         floor_v;
	logic [1:0]         idx_n;
	logic [9:0]         target_n;

	assign adv       = !tgt_valid_q || tgt_ready;
	assign det_ready = !valid_s1 || adv;
	assign cfg_ready = 1'b1;
	assign tgt_valid = tgt_valid_q;
	assign tgt       = tgt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			preset_mode_q <= 1'b0;
			target_max_q  <= RST_TARGET_MAX;
			target_min_q  <= RST_TARGET_MIN;
			window_q      <= RST_WINDOW_MS;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_PRESET_MODE: preset_mode_q <= cfg_data[0];
				CFG_TARGET_MAX:  target_max_q  <= cfg_data[9:0];
				CFG_TARGET_MIN:  target_min_q  <= cfg_data[9:0];
				CFG_WINDOW_MS:   window_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	// acceleration: count of detents within the window
	always_comb begin
		gap     = det_s1.tick_ms - last_time_q;
		restart = (last_time_q == 32'd0) || (gap > {16'd0, window_q});
		if (restart)
			count_n = 4'd1;
		else if (count_q < COUNT_MAX)
			count_n = count_q + 4'd1;
		else
			count_n = count_q;
		case (count_n) inside
			[4'd4:4'd6]:   step = STEP_UNIT * 5'd2;
			[4'd7:4'd9]:   step = STEP_UNIT * 5'd3;
			[4'd10:4'd12]: step = STEP_UNIT * 5'd4;
			[4'd13:4'd15]: step = STEP_UNIT * 5'd5;
			default:       step = STEP_UNIT;
		endcase
	end

	always_comb begin
		floor_v  = (target_min_q < {5'd0, STEP_UNIT}) ? 10'd0
			: target_min_q - {5'd0, STEP_UNIT};
		up_sum   = {1'b0, target_q} + {6'd0, step};
		dn_diff  = $signed({1'b0, target_q}) - $signed({6'd0, step});
		idx_n    = preset_idx_q;
		target_n = target_q;
		take_step = 1'b0;
		if (preset_mode_q) begin
			if (det_s1.direction_up) begin
				if (preset_idx_q < PRESET_IDX_MAX)
					idx_n = preset_idx_q + 2'd1;
			end else if (preset_idx_q > 2'd1) begin
				idx_n = preset_idx_q - 2'd1;
			end
			case (idx_n)
				2'd2:    target_n = PRESET_BASE + PRESET_SPACING;
				2'd3:    target_n = PRESET_BASE + PRESET_SPACING + PRESET_SPACING;
				default: target_n = PRESET_BASE;
			endcase
		end else if (det_s1.direction_up) begin
			take_step = target_q < target_max_q;
			if (take_step) begin
				if (up_sum > {1'b0, target_max_q})
					target_n = target_max_q;
				else
					target_n = up_sum[9:0];
			end else if (target_q > target_max_q) begin
				target_n = target_max_q;
			end
		end else begin
			take_step = target_q >= target_min_q;
			if (take_step) begin
				if (dn_diff < $signed({1'b0, floor_v}))
					target_n = floor_v;
				else
					target_n = dn_diff[9:0];
			end else if (target_q < floor_v) begin
				target_n = floor_v;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			tgt_valid_q  <= 1'b0;
			last_time_q  <= 32'd0;
			count_q      <= 4'd0;
			target_q     <= RST_TARGET;
			preset_idx_q <= RST_PRESET_IDX;
		end else begin
			if (det_ready)
				valid_s1 <= det_valid;
			if (adv)
				tgt_valid_q <= valid_s1;
			if (valid_s1 && adv) begin
				target_q     <= target_n;
				preset_idx_q <= idx_n;
				if (take_step) begin
					last_time_q <= det_s1.tick_ms;
					count_q     <= count_n;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (det_ready && det_valid)
			det_s1 <= det;
		if (valid_s1 && adv) begin
			tgt_q.target_value <= target_n;
			tgt_q.step_applied <= take_step ? step : 5'd0;
		end
	end

	`EATS_ASSERT(a_step_legal, !tgt_valid || tgt.step_applied == 5'd0 || tgt.step_applied == 5'd5 || tgt.step_applied == 5'd10 || tgt.step_applied == 5'd15 || tgt.step_applied == 5'd20 || tgt.step_applied == 5'd25)
	`EATS_ASSERT(a_preset_no_step, !(tgt_valid && preset_mode_q) || tgt.step_applied == 5'd0)
	`EATS_ASSERT_NEXT(a_s1_hold, valid_s1 && !adv, valid_s1 && $stable(det_s1))
	`EATS_ASSERT_NEXT(a_count_live, valid_s1 && adv && take_step, count_q != 4'd0)

endmodule

// ===== tb/sv/encoder_accel_target_setpoint_top_tb.sv =====
`timescale 1ns / 1ps
// Testbench for encoder_accel_target_setpoint_top: directed and random detent requests,
// each result checked against a predictor of the setpoint and acceleration state.
// Depends on eats_pkg and the block's RTL.

module encoder_accel_target_setpoint_top_tb;
	import eats_pkg::*;

	localparam logic DIR_UP      = 1'b1;
	localparam logic DIR_DOWN    = 1'b0;
	localparam int   BUCKET      = 3;
	localparam int   LEVEL_MAX   = 5;
	localparam int   MAX_REPORTS = 10;

	typedef enum int {RX_FULL, RX_MOSTLY, RX_HALF, RX_SPARSE} rx_mode_e;

	logic        clk;
	logic        arst_n;
	logic        det_valid;
	logic        det_ready;
	det_t        det;
	logic        tgt_valid;
	logic        tgt_ready;
	tgt_t        tgt;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;

	// predictor copy of registers and state
	logic        cf_preset;
	logic [9:0]  cf_max;
	logic [9:0]  cf_min;
	logic [15:0] cf_window;
	logic [31:0] prev_detent_ms;
	logic [3:0]  run_len;
	logic [9:0]  setpoint;
	logic [1:0]  preset_sel;

	tgt_t        pending_targets[$];
	tgt_t        want_tgt;
	int          mismatch_cnt;
	int          hold_off_cycles;
	int          burst_left;
	bit          gapless;
	logic [31:0] now_ms;

	encoder_accel_target_setpoint_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.det_valid (det_valid),
		.det_ready (det_ready),
		.det       (det),
		.tgt_valid (tgt_valid),
		.tgt_ready (tgt_ready),
		.tgt       (tgt),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic logic [4:0] accel_step(input logic [31:0] tick);
		logic [31:0] gap;
		int          level;
		gap = tick - prev_detent_ms;
		if (prev_detent_ms == 32'd0 || gap > {16'd0, cf_window})
			run_len = 4'd1;
		else if (run_len < COUNT_MAX)
			run_len = run_len + 4'd1;
		prev_detent_ms = tick;
		level = (int'(run_len) + BUCKET - 1) / BUCKET;
		if (level > LEVEL_MAX)
			level = LEVEL_MAX;
		return 5'(level) * STEP_UNIT;
	endfunction

	function automatic tgt_t predict_target(input det_t d);
		tgt_t       r;
		int         t;
		int         floor_v;
		logic [4:0] step;
		step = 5'd0;
		if (cf_preset) begin
			if (d.direction_up) begin
				if (preset_sel < PRESET_IDX_MAX)
					preset_sel = preset_sel + 2'd1;
			end else begin
				if (preset_sel > 2'd1)
					preset_sel = preset_sel - 2'd1;
			end
			setpoint = (preset_sel == 2'd0) ? PRESET_BASE
				: PRESET_BASE + 10'(preset_sel - 2'd1) * PRESET_SPACING;
		end else if (d.direction_up) begin
			t = int'(setpoint);
			if (setpoint < cf_max) begin
				step = accel_step(d.tick_ms);
				t = t + int'(step);
			end
			if (t > int'(cf_max))
				t = int'(cf_max);
			setpoint = t[9:0];
		end else begin
			t = int'(setpoint);
			floor_v = int'(cf_min) - int'(STEP_UNIT);
			if (floor_v < 0)
				floor_v = 0;
			if (setpoint >= cf_min) begin
				step = accel_step(d.tick_ms);
				t = t - int'(step);
			end
			if (t < floor_v)
				t = floor_v;
			setpoint = t[9:0];
		end
		r.target_value = setpoint;
		r.step_applied = step;
		return r;
	endfunction

	// valid stays high across a burst; the next request must follow in the same step
	task automatic send_detent(input logic dir, input logic [31:0] tick);
		det_t d;
		d.direction_up = dir;
		d.tick_ms      = tick;
		det       <= d;
		det_valid <= 1'b1;
		@(posedge clk);
		while (!det_ready)
			@(posedge clk);
		pending_targets.push_back(predict_target(d));
		if (!gapless) begin
			burst_left--;
			if (burst_left <= 0) begin
				burst_left = $urandom_range(1, 32);
				det_valid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
	endtask

	task automatic pause_sender();
		if (det_valid) begin
			det_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
		pause_sender();
		while (pending_targets.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		cfg_index <= idx;
		cfg_data  <= value;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_PRESET_MODE: cf_preset = value[0];
			CFG_TARGET_MAX:  cf_max    = value[9:0];
			CFG_TARGET_MIN:  cf_min    = value[9:0];
			CFG_WINDOW_MS:   cf_window = value;
			default:         ;
		endcase
	endtask

	task automatic spin(input logic dir, input int count, input logic [31:0] delta_ms);
		repeat (count) begin
			now_ms = now_ms + delta_ms;
			send_detent(dir, now_ms);
		end
	endtask

	// reset settings: accelerate up to the max, last one blocked
	task automatic test_accel_default();
		spin(DIR_UP, 13, 32'd20);
	endtask

	// zero stored time restarts the count; gap wraps through 2^32
	task automatic test_time_edges();
		send_detent(DIR_DOWN, 32'd0);
		send_detent(DIR_DOWN, 32'hFFFF_FFFF);
		send_detent(DIR_DOWN, 32'h0000_0010);
		now_ms = 32'h0000_0010;
	endtask

	// tiny limits: min below the step unit, decrease that goes past zero
	task automatic test_small_limits();
		write_reg(CFG_TARGET_MIN, 16'd3);
		write_reg(CFG_WINDOW_MS, 16'hFFFF);
		write_reg(CFG_TARGET_MAX, 16'd10);
		spin(DIR_UP, 1, 32'd1);
		spin(DIR_DOWN, 2, 32'd1);
	endtask

	task automatic test_preset();
		write_reg(CFG_PRESET_MODE, 16'd1);
		spin(DIR_UP, 3, 32'd1);
		spin(DIR_DOWN, 3, 32'd1);
	endtask

	// receiver holds off long enough for the input to back up
	task automatic test_backpressure();
		write_reg(CFG_PRESET_MODE, 16'd0);
		write_reg(CFG_TARGET_MAX, {6'd0, RST_TARGET_MAX});
		write_reg(CFG_TARGET_MIN, {6'd0, RST_TARGET_MIN});
		write_reg(CFG_WINDOW_MS, RST_WINDOW_MS);
		gapless = 1'b1;
		hold_off_cycles = 80;
		spin(DIR_UP, 10, 32'd15);
		spin(DIR_DOWN, 6, 32'd15);
		gapless = 1'b0;
	endtask

	// mostly rotations inside the window, some long pauses, jumps and reversals
	task automatic random_detents(input int items);
		int   sent;
		int   run;
		int   sel;
		logic dir;
		sent = 0;
		while (sent < items) begin
			dir = 1'($urandom_range(0, 1));
			run = $urandom_range(1, 20);
			while (run > 0 && sent < items) begin
				sel = $urandom_range(0, 19);
				if (sel == 0)
					now_ms = $urandom;
				else if (sel <= 2)
					now_ms = now_ms + {16'd0, cf_window} + $urandom_range(1, 5000);
				else
					now_ms = now_ms + $urandom_range(0, cf_window);
				if (sel == 3)
					dir = ~dir;
				send_detent(dir, now_ms);
				sent++;
				run--;
			end
		end
	endtask

	task automatic test_random();
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin
					write_reg(CFG_PRESET_MODE, 16'd0);
					write_reg(CFG_TARGET_MAX, {6'd0, RST_TARGET_MAX});
					write_reg(CFG_TARGET_MIN, {6'd0, RST_TARGET_MIN});
					write_reg(CFG_WINDOW_MS, RST_WINDOW_MS);
				end
				1: begin
					write_reg(CFG_WINDOW_MS, 16'd0);
					write_reg(CFG_TARGET_MAX, 16'd1023);
					write_reg(CFG_TARGET_MIN, 16'd1023);
				end
				2: begin
					write_reg(CFG_WINDOW_MS, 16'hFFFF);
					write_reg(CFG_TARGET_MAX, 16'd5);
					write_reg(CFG_TARGET_MIN, 16'd5);
				end
				default: begin
					write_reg(CFG_PRESET_MODE,
						{15'($urandom), 1'($urandom_range(0, 2) == 0)});
					write_reg(CFG_TARGET_MAX,
						{6'($urandom), 10'($urandom_range(5, 1023))});
					write_reg(CFG_TARGET_MIN,
						{6'($urandom), 10'($urandom_range(0, 1023))});
					write_reg(CFG_WINDOW_MS, 16'($urandom_range(0, 2000)));
				end
			endcase
			random_detents(80);
		end
	endtask

	// receiver: random ready pattern, plus long hold-offs on request
	initial begin
		rx_mode_e rx_mode;
		int       mode_left;
		int       stall_left;
		tgt_ready <= 1'b0;
		rx_mode = RX_FULL;
		mode_left = 0;
		forever begin
			@(posedge clk);
			if (hold_off_cycles > 0) begin
				stall_left = hold_off_cycles;
				hold_off_cycles = 0;
				tgt_ready <= 1'b0;
				while (stall_left > 0) begin
					@(posedge clk);
					stall_left--;
				end
			end else begin
				if (mode_left == 0) begin
					rx_mode = rx_mode_e'($urandom_range(0, 3));
					mode_left = $urandom_range(16, 96);
				end
				mode_left--;
				case (rx_mode)
					RX_FULL:   tgt_ready <= 1'b1;
					RX_MOSTLY: tgt_ready <= ($urandom_range(0, 3) != 0);
					RX_HALF:   tgt_ready <= 1'($urandom_range(0, 1));
					default:   tgt_ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && tgt_valid && tgt_ready) begin
			if (pending_targets.size() == 0) begin
				mismatch_cnt++;
				if (mismatch_cnt <= MAX_REPORTS)
					$display("%0t: unexpected result target %0d step %0d",
						$time, tgt.target_value, tgt.step_applied);
			end else begin
				want_tgt = pending_targets.pop_front();
				if (tgt.target_value !== want_tgt.target_value ||
						tgt.step_applied !== want_tgt.step_applied) begin
					mismatch_cnt++;
					if (mismatch_cnt <= MAX_REPORTS)
						$display("%0t: expected target %0d step %0d, got target %0d step %0d",
							$time, want_tgt.target_value, want_tgt.step_applied,
							tgt.target_value, tgt.step_applied);
				end
			end
		end
	end

	initial begin
		#2_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		arst_n    <= 1'b0;
		det_valid <= 1'b0;
		det       <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_PRESET_MODE;
		cfg_data  <= '0;
		cf_preset  = 1'b0;
		cf_max     = RST_TARGET_MAX;
		cf_min     = RST_TARGET_MIN;
		cf_window  = RST_WINDOW_MS;
		prev_detent_ms = 32'd0;
		run_len    = 4'd0;
		setpoint   = RST_TARGET;
		preset_sel = RST_PRESET_IDX;
		mismatch_cnt    = 0;
		hold_off_cycles = 0;
		burst_left      = $urandom_range(1, 32);
		gapless         = 1'b0;
		now_ms          = 32'd1000;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		test_accel_default();
		test_time_edges();
		test_small_limits();
		test_preset();
		test_backpressure();
		test_random();

		pause_sender();
		while (pending_targets.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatch_cnt == 0 && pending_targets.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/eats_pkg.sv
rtl/encoder_accel_target_setpoint_top.sv
tb/sv/encoder_accel_target_setpoint_top_tb.sv
